>>> design/cwis_pkg.sv
package cwis_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned TotalW = 16;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned StepW  = 6;

  // Number of restoring steps for the two kinds of division.
  localparam logic [StepW-1:0] DivStepsMod = 6'd32;
  localparam logic [StepW-1:0] DivStepsSq  = 6'd16;

  typedef enum logic [2:0] {
    CURVE_LIN_INC = 3'd0,
    CURVE_LIN_DEC = 3'd1,
    CURVE_BELL    = 3'd2,
    CURVE_EXP_INC = 3'd3,
    CURVE_EXP_DEC = 3'd4,
    CURVE_FLAT    = 3'd5,
    CURVE_TRI     = 3'd6
  } curve_e;

  typedef enum logic {
    CFG_CURVE_MODE = 1'b0,
    CFG_RANGE_SIZE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic [WordW-1:0]  dividend;
    logic [TotalW-1:0] divisor;
    logic [StepW-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WordW-1:0]  quotient;
    logic [TotalW-1:0] remainder;
  } div_rsp_t;

endpackage

>>> design/cwis_div.sv
module cwis_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cwis_pkg::div_req_t req_i,
  output cwis_pkg::div_rsp_t rsp_o
);
  import cwis_pkg::*;

  // Restoring divider, one quotient bit per cycle. The dividend is left
  // aligned, so a run of k steps divides its top k bits.
  logic [TotalW-1:0] rem_q, rem_d;
  logic [WordW-1:0]  quo_q, quo_d;
  logic [TotalW-1:0] dsr_q;
  logic [StepW-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [TotalW:0]   shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_q, quo_q[WordW-1]};
    fits    = (shifted >= {1'b0, dsr_q});
    rem_d   = fits ? TotalW'(shifted - {1'b0, dsr_q}) : shifted[TotalW-1:0];
    quo_d   = {quo_q[WordW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - StepW'(1);
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> design/curve_weighted_index_sampler.sv
// Curve-weighted index sampler. Each request carries a 32-bit random word;
// the block answers with one index in 0..range_size-1, drawn with the
// weights of the curve chosen by curve_mode (rising, falling, bell,
// quadratic rising, quadratic falling, flat, triangle; the unused code
// behaves as flat). The running sums of the weights live in a 256 x 16-bit
// synchronous memory. After reset or any configuration write the first
// request rebuilds that table, one index at a time, with a square and a
// division for the quadratic modes, whose weights need a 16-step division.
// With the table in place a request runs the 32-step modulo of the random
// word by the total weight in the shared restoring divider, then a binary
// search of one to eight probes of the synchronously read table memory,
// then loads the result register. A range_size below two skips the modulo
// and the search and loads 0 into the result register.
// One request is in flight at a time; a finished result waits in its
// output register while the block is already free for the next one.
module curve_weighted_index_sampler (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [7:0]              cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [31:0]             random_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              chosen_index_o
);
  import cwis_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_SQ,
    ST_BLD_DIVGO,
    ST_BLD_DIVW,
    ST_BLD_WR,
    ST_MOD_GO,
    ST_MOD_W,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_DONE
  } state_e;

  // Configuration registers and the flag that says the table matches them.
  logic [2:0]      curve_q;
  logic [IdxW-1:0] range_q;
  logic            table_ok_q;

  state_e            state_q;
  logic [WordW-1:0]  word_q;
  logic [IdxW-1:0]   idx_q;
  logic [TotalW-1:0] cumul_q;
  logic [TotalW-1:0] total_q;
  logic [TotalW-1:0] reduced_q;
  logic [IdxW-1:0]   lo_q, hi_q, mid_q;
  logic [TotalW-1:0] sq_q;
  logic              out_valid_q;
  logic [IdxW-1:0]   out_index_q;

  // Table of running sums: entry i holds w(0) + ... + w(i).
  logic [TotalW-1:0] cum_mem [2**IdxW];
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [TotalW-1:0] mem_wdata;
  logic [IdxW-1:0]   mem_raddr;
  logic [TotalW-1:0] mem_rdata_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic            quad_mode;
  logic [IdxW-1:0] half;
  logic [IdxW-1:0] last_idx;
  logic [IdxW-1:0] sq_base;
  logic [IdxW-1:0] weight;
  logic [TotalW-1:0] cumul_next;
  logic [IdxW:0]   mid_sum;

  assign quad_mode = (curve_q == CURVE_EXP_INC) || (curve_q == CURVE_EXP_DEC);
  assign half      = range_q >> 1;
  assign last_idx  = range_q - IdxW'(1);
  // Quadratic rising squares i, quadratic falling squares the distance
  // from the last index.
  assign sq_base   = (curve_q == CURVE_EXP_DEC) ? (last_idx - idx_q) : idx_q;
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};

  // Weight of the current index. The quotient of the square by n-1 never
  // exceeds n-1, so its low byte is exact.
  always_comb begin
    unique case (curve_q)
      CURVE_LIN_INC: weight = idx_q + IdxW'(1);
      CURVE_LIN_DEC: weight = range_q - idx_q;
      CURVE_BELL:    weight = (idx_q <= half) ? idx_q + IdxW'(1) : range_q - idx_q;
      CURVE_EXP_INC,
      CURVE_EXP_DEC: weight = div_rsp.quotient[IdxW-1:0] + IdxW'(1);
      CURVE_TRI: begin
        if (idx_q <= half) begin
          weight = IdxW'({idx_q, 1'b1});
        end else begin
          weight = IdxW'({IdxW'(range_q - idx_q - IdxW'(1)), 1'b1});
        end
      end
      default:       weight = IdxW'(1);
    endcase
  end

  assign cumul_next = cumul_q + TotalW'(weight);

  always_comb begin
    div_req = '0;
    if (state_q == ST_BLD_DIVGO) begin
      div_req.start    = 1'b1;
      div_req.dividend = {sq_q, {(WordW-TotalW){1'b0}}};
      div_req.divisor  = TotalW'(last_idx);
      div_req.steps    = DivStepsSq;
    end else if (state_q == ST_MOD_GO) begin
      div_req.start    = 1'b1;
      div_req.dividend = word_q;
      div_req.divisor  = total_q;
      div_req.steps    = DivStepsMod;
    end
  end

  cwis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign mem_we    = (state_q == ST_BLD_WR);
  assign mem_waddr = idx_q;
  assign mem_wdata = cumul_next;
  assign mem_raddr = mid_sum[IdxW:1];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cum_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= cum_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q     <= 3'(CURVE_LIN_INC);
      range_q     <= 8'd16;
      table_ok_q  <= 1'b0;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A result that leaves while a new one is being loaded is replaced
      // in the done state below.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        table_ok_q <= 1'b0;
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_CURVE_MODE: curve_q <= cfg_data_i[2:0];
          CFG_RANGE_SIZE: range_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            word_q  <= random_word_i;
            idx_q   <= '0;
            cumul_q <= '0;
            lo_q    <= '0;
            hi_q    <= last_idx;
            if (range_q < 8'd2) begin
              // With fewer than two choices the answer is always zero.
              state_q <= ST_DONE;
            end else if (table_ok_q) begin
              state_q <= ST_MOD_GO;
            end else begin
              state_q <= ST_BLD_SQ;
            end
          end
        end
        ST_BLD_SQ: begin
          sq_q    <= TotalW'(sq_base) * TotalW'(sq_base);
          state_q <= quad_mode ? ST_BLD_DIVGO : ST_BLD_WR;
        end
        ST_BLD_DIVGO: begin
          state_q <= ST_BLD_DIVW;
        end
        ST_BLD_DIVW: begin
          if (div_rsp.done) begin
            state_q <= ST_BLD_WR;
          end
        end
        ST_BLD_WR: begin
          cumul_q <= cumul_next;
          if (idx_q == last_idx) begin
            total_q <= cumul_next;
            if (!cfg_we_i) begin
              table_ok_q <= 1'b1;
            end
            state_q <= ST_MOD_GO;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= ST_BLD_SQ;
          end
        end
        ST_MOD_GO: begin
          state_q <= ST_MOD_W;
        end
        ST_MOD_W: begin
          if (div_rsp.done) begin
            reduced_q <= div_rsp.remainder;
            state_q   <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          // The last entry equals the total, which always exceeds the
          // reduced value, so the search always ends on a valid index.
          if (lo_q == hi_q) begin
            state_q <= ST_DONE;
          end else begin
            mid_q   <= mid_sum[IdxW:1];
            state_q <= ST_SRCH_CMP;
          end
        end
        ST_SRCH_CMP: begin
          if (reduced_q < mem_rdata_q) begin
            hi_q <= mid_q;
          end else begin
            lo_q <= mid_q + IdxW'(1);
          end
          state_q <= ST_SRCH;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_index_q <= lo_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign chosen_index_o = out_index_q;

endmodule
